/* src/mdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mdc_pkg;

   localparam int OBJ_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = 49;
   localparam int SUM_W      = PROD_W + 2;
   localparam int DIFF_OUT_W = SUM_W - FRAC_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int COUNT_W    = 3;
   localparam int SEL_W      = 2;
   localparam int TABLE_W    = 64;

   typedef enum logic [2:0] {
      MODE_FIRST   = 3'd0,
      MODE_PARETO  = 3'd1,
      MODE_WEAK    = 3'd2,
      MODE_STRONG  = 3'd3,
      MODE_EPSILON = 3'd4,
      MODE_SCALAR  = 3'd5,
      MODE_SELECT  = 3'd6
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] REG_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SELECT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHTS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EPSILONS = 3'd4;

   localparam logic [1:0] ORDER_FIRST  = 2'b11;
   localparam logic [1:0] ORDER_NONE   = 2'b00;
   localparam logic [1:0] ORDER_SECOND = 2'b01;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;

   typedef struct packed {
      logic lt;
      logic gt;
   } lane_flags_type;

endpackage

`default_nettype wire

/* src/mdc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mdc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] first_obj0;
   logic signed [31:0] first_obj1;
   logic signed [31:0] first_obj2;
   logic signed [31:0] first_obj3;
   logic signed [31:0] second_obj0;
   logic signed [31:0] second_obj1;
   logic signed [31:0] second_obj2;
   logic signed [31:0] second_obj3;

   modport source (output valid, first_obj0, first_obj1, first_obj2, first_obj3,
                   second_obj0, second_obj1, second_obj2, second_obj3, input ready);
   modport sink (input valid, first_obj0, first_obj1, first_obj2, first_obj3,
                 second_obj0, second_obj1, second_obj2, second_obj3, output ready);
endinterface

interface mdc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [1:0]  order;
   logic               first_before;
   logic signed [34:0] weighted_difference;

   modport source (output valid, order, first_before, weighted_difference, input ready);
   modport sink (input valid, order, first_before, weighted_difference, output ready);
endinterface

interface mdc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/mdc_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module mdc_lane (
   input  wire logic                                  clock,
   input  wire logic                                  en_a,
   input  wire logic                                  en_b,
   input  wire logic                                  eps_on,
   input  wire logic signed [mdc_pkg::OBJ_W-1:0]      a,
   input  wire logic signed [mdc_pkg::OBJ_W-1:0]      b,
   input  wire logic        [mdc_pkg::COEF_W-1:0]     weight,
   input  wire logic        [mdc_pkg::COEF_W-1:0]     epsilon,
   output mdc_pkg::lane_flags_type                    flags,
   output logic signed      [mdc_pkg::PROD_W-1:0]     wprod
);

   logic        [mdc_pkg::COEF_W:0]        scale;
   logic signed [mdc_pkg::PROD_W:0]        lhs_full;
   logic signed [mdc_pkg::OBJ_W:0]         diff;
   logic signed [mdc_pkg::PROD_W:0]        wprod_full;
   logic signed [mdc_pkg::PROD_W-1:0]      lhs_ff, lhs_in;
   logic signed [mdc_pkg::OBJ_W-1:0]       b_ff;
   logic signed [mdc_pkg::PROD_W-1:0]      wprod_a_ff, wprod_a_in;
   logic signed [mdc_pkg::PROD_W-1:0]      rhs;
   mdc_pkg::lane_flags_type                flags_ff, flags_in;
   logic signed [mdc_pkg::PROD_W-1:0]      wprod_b_ff;

   // The first vector is scaled by one plus epsilon (epsilon is zero unless eps_on) so both sides sit in Q17.32.
   always_comb begin
      scale      = {1'b1, (eps_on ? epsilon : {mdc_pkg::COEF_W{1'b0}})};
      lhs_full   = (mdc_pkg::PROD_W+1)'(a) * $signed({1'b0, scale});
      lhs_in     = lhs_full[mdc_pkg::PROD_W-1:0];
      diff       = $signed({a[mdc_pkg::OBJ_W-1], a}) - $signed({b[mdc_pkg::OBJ_W-1], b});
      wprod_full = (mdc_pkg::PROD_W+1)'(diff) * $signed({1'b0, weight});
      wprod_a_in = wprod_full[mdc_pkg::PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         lhs_ff     <= lhs_in;
         b_ff       <= b;
         wprod_a_ff <= wprod_a_in;
      end
   end

   always_comb begin
      rhs         = $signed({b_ff[mdc_pkg::OBJ_W-1], b_ff, {mdc_pkg::FRAC_W{1'b0}}});
      flags_in.lt = lhs_ff < rhs;
      flags_in.gt = lhs_ff > rhs;
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         flags_ff   <= flags_in;
         wprod_b_ff <= wprod_a_ff;
      end
   end

   assign flags = flags_ff;
   assign wprod = wprod_b_ff;

endmodule

`default_nettype wire

/* src/mdc_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module mdc_merge #(
   parameter int MAX_OBJECTIVES = 4
) (
   input  wire logic                                    clock,
   input  wire logic                                    en_c,
   input  wire logic                                    en_d,
   input  wire logic [2:0]                              mode,
   input  wire logic [mdc_pkg::COUNT_W-1:0]             count,
   input  wire logic [mdc_pkg::SEL_W-1:0]               sel,
   input  wire mdc_pkg::lane_flags_type                 flags [MAX_OBJECTIVES],
   input  wire logic signed [mdc_pkg::PROD_W-1:0]       wprods [MAX_OBJECTIVES],
   output logic signed [1:0]                            order,
   output logic                                         first_before,
   output logic signed [mdc_pkg::DIFF_OUT_W-1:0]        weighted_difference
);

   localparam logic [mdc_pkg::COUNT_W-1:0] LANES = mdc_pkg::COUNT_W'(MAX_OBJECTIVES);

   logic [mdc_pkg::COUNT_W-1:0]          n_eff;
   logic [MAX_OBJECTIVES-1:0]            use_in, lt_in, gt_in, sel_hit;
   logic signed [mdc_pkg::SUM_W-1:0]     sum_in;
   logic [MAX_OBJECTIVES-1:0]            use_ff, lt_ff, gt_ff;
   logic signed [mdc_pkg::SUM_W-1:0]     sum_ff;
   logic                                 any_lt, any_gt, all_lt, all_gt, sel_lt, sel_gt;
   logic [1:0]                           order_in;
   logic [1:0]                           order_ff;
   logic                                 fb_ff;
   logic signed [mdc_pkg::DIFF_OUT_W-1:0] wd_ff;

   always_comb begin
      if (count == '0) begin
         n_eff = mdc_pkg::COUNT_W'(1);
      end else if (count > LANES) begin
         n_eff = LANES;
      end else begin
         n_eff = count;
      end
      sum_in = '0;
      for (int i = 0; i < MAX_OBJECTIVES; i++) begin
         use_in[i] = mdc_pkg::COUNT_W'(i) < n_eff;
         lt_in[i]  = flags[i].lt & use_in[i];
         gt_in[i]  = flags[i].gt & use_in[i];
         if (use_in[i]) begin
            sum_in = sum_in + mdc_pkg::SUM_W'(wprods[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         use_ff <= use_in;
         lt_ff  <= lt_in;
         gt_ff  <= gt_in;
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_OBJECTIVES; i++) begin
         sel_hit[i] = mdc_pkg::SEL_W'(i) == sel;
      end
      any_lt = |lt_ff;
      any_gt = |gt_ff;
      all_lt = &(lt_ff | ~use_ff);
      all_gt = &(gt_ff | ~use_ff);
      sel_lt = |(lt_ff & sel_hit);
      sel_gt = |(gt_ff & sel_hit);
      order_in = mdc_pkg::ORDER_NONE;
      unique case (mdc_pkg::mode_type'(mode))
         mdc_pkg::MODE_FIRST: begin
            if (lt_ff[0]) order_in = mdc_pkg::ORDER_FIRST;
            else if (gt_ff[0]) order_in = mdc_pkg::ORDER_SECOND;
         end
         mdc_pkg::MODE_PARETO: begin
            if (any_lt && !any_gt) order_in = mdc_pkg::ORDER_FIRST;
            else if (any_gt && !any_lt) order_in = mdc_pkg::ORDER_SECOND;
         end
         mdc_pkg::MODE_WEAK, mdc_pkg::MODE_EPSILON: begin
            if (!gt_ff[0]) begin
               order_in = any_gt ? mdc_pkg::ORDER_NONE : mdc_pkg::ORDER_FIRST;
            end else begin
               order_in = any_lt ? mdc_pkg::ORDER_NONE : mdc_pkg::ORDER_SECOND;
            end
         end
         mdc_pkg::MODE_STRONG: begin
            if (all_lt) order_in = mdc_pkg::ORDER_FIRST;
            else if (all_gt) order_in = mdc_pkg::ORDER_SECOND;
         end
         mdc_pkg::MODE_SCALAR: begin
            if (sum_ff[mdc_pkg::SUM_W-1]) order_in = mdc_pkg::ORDER_FIRST;
            else if (sum_ff != '0) order_in = mdc_pkg::ORDER_SECOND;
         end
         mdc_pkg::MODE_SELECT: begin
            if (sel_lt) order_in = mdc_pkg::ORDER_FIRST;
            else if (sel_gt) order_in = mdc_pkg::ORDER_SECOND;
         end
         default: order_in = mdc_pkg::ORDER_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         order_ff <= order_in;
         fb_ff    <= order_in == mdc_pkg::ORDER_FIRST;
         wd_ff    <= sum_ff[mdc_pkg::SUM_W-1:mdc_pkg::FRAC_W];
      end
   end

   assign order               = order_ff;
   assign first_before        = fb_ff;
   assign weighted_difference = wd_ff;

endmodule

`default_nettype wire

/* src/multiobjective_dominance_compare.sv */
// Channel   Direction  Contents
// req_chan  in         two vectors of four signed Q16.16 objectives
// rsp_chan  out        order, first_before flag, weighted difference
// csr_chan  in         register index and 64-bit write data
//
// Each word passes four register stages: lane product, compare, masked sum and decision.
// Its result becomes valid when the decision register captures it.
// One word is accepted per cycle unless a stall backs up to the input; every stage is registered.
// Reset is synchronous and active high; it clears valid bits and settings, but count resets to 4.
// A stalled output holds its word, and earlier stages keep filling until all are full.
`timescale 1ns / 1ps
`default_nettype none

module multiobjective_dominance_compare #(
   parameter int MAX_OBJECTIVES = 4
) (
   input wire logic  clock,
   input wire logic  reset,
   mdc_req_if.sink   req_chan,
   mdc_rsp_if.source rsp_chan,
   mdc_csr_if.sink   csr_chan
);

   logic [2:0]                          mode_ff;
   logic [mdc_pkg::COUNT_W-1:0]         count_ff;
   logic [mdc_pkg::SEL_W-1:0]           sel_ff;
   logic [mdc_pkg::TABLE_W-1:0]         weight_ff;
   logic [mdc_pkg::TABLE_W-1:0]         eps_ff;
   logic                                va_ff, vb_ff, vc_ff, vd_ff;
   logic                                rdy_a, rdy_b, rdy_c, rdy_d;
   logic signed [mdc_pkg::OBJ_W-1:0]    a_arr [4];
   logic signed [mdc_pkg::OBJ_W-1:0]    b_arr [4];
   mdc_pkg::lane_flags_type             flags [MAX_OBJECTIVES];
   logic signed [mdc_pkg::PROD_W-1:0]   wprods [MAX_OBJECTIVES];
   logic                                eps_on;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= mdc_pkg::MODE_FIRST;
         count_ff  <= mdc_pkg::COUNT_RESET;
         sel_ff    <= '0;
         weight_ff <= '0;
         eps_ff    <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            mdc_pkg::REG_MODE:     mode_ff   <= csr_chan.data[2:0];
            mdc_pkg::REG_COUNT:    count_ff  <= csr_chan.data[mdc_pkg::COUNT_W-1:0];
            mdc_pkg::REG_SELECT:   sel_ff    <= csr_chan.data[mdc_pkg::SEL_W-1:0];
            mdc_pkg::REG_WEIGHTS:  weight_ff <= csr_chan.data;
            mdc_pkg::REG_EPSILONS: eps_ff    <= csr_chan.data;
            default: ;
         endcase
      end
   end

   assign rdy_d = !vd_ff || rsp_chan.ready;
   assign rdy_c = !vc_ff || rdy_d;
   assign rdy_b = !vb_ff || rdy_c;
   assign rdy_a = !va_ff || rdy_b;
   assign req_chan.ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= req_chan.valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_d) vd_ff <= vc_ff;
      end
   end

   always_comb begin
      a_arr[0] = req_chan.first_obj0;
      a_arr[1] = req_chan.first_obj1;
      a_arr[2] = req_chan.first_obj2;
      a_arr[3] = req_chan.first_obj3;
      b_arr[0] = req_chan.second_obj0;
      b_arr[1] = req_chan.second_obj1;
      b_arr[2] = req_chan.second_obj2;
      b_arr[3] = req_chan.second_obj3;
   end

   assign eps_on = mode_ff == mdc_pkg::MODE_EPSILON;

   for (genvar i = 0; i < MAX_OBJECTIVES; i++) begin : g_lane
      mdc_lane u_lane (
         .clock   (clock),
         .en_a    (rdy_a),
         .en_b    (rdy_b),
         .eps_on  (eps_on),
         .a       (a_arr[i]),
         .b       (b_arr[i]),
         .weight  (weight_ff[mdc_pkg::COEF_W*i +: mdc_pkg::COEF_W]),
         .epsilon (eps_ff[mdc_pkg::COEF_W*i +: mdc_pkg::COEF_W]),
         .flags   (flags[i]),
         .wprod   (wprods[i])
      );
   end

   mdc_merge #(
      .MAX_OBJECTIVES (MAX_OBJECTIVES)
   ) u_merge (
      .clock               (clock),
      .en_c                (rdy_c),
      .en_d                (rdy_d),
      .mode                (mode_ff),
      .count               (count_ff),
      .sel                 (sel_ff),
      .flags               (flags),
      .wprods              (wprods),
      .order               (rsp_chan.order),
      .first_before        (rsp_chan.first_before),
      .weighted_difference (rsp_chan.weighted_difference)
   );

   assign rsp_chan.valid = vd_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !va_ff && !vb_ff && !vc_ff)
      else $error("pipeline not empty after reset");

   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.first_before == (rsp_chan.order == mdc_pkg::ORDER_FIRST))
      else $error("first_before disagrees with order");

   a_order_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.order != 2'b10)
      else $error("order holds an undefined code");

   a_scalar_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && mode_ff == mdc_pkg::MODE_SCALAR
         && rsp_chan.order == mdc_pkg::ORDER_FIRST |-> rsp_chan.weighted_difference[34])
      else $error("scalar order first with non-negative difference");

   a_scalar_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && mode_ff == mdc_pkg::MODE_SCALAR
         && rsp_chan.order == mdc_pkg::ORDER_SECOND |-> !rsp_chan.weighted_difference[34])
      else $error("scalar order second with negative difference");

endmodule

`default_nettype wire

/* sim/tb_multiobjective_dominance_compare.sv */
`timescale 1ns / 1ps

module tb_multiobjective_dominance_compare;

   localparam int LANES = 4;
   localparam int PHASES = 11;
   localparam int PHASE_WORDS = 50;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int Q_MAX = 32'sh7FFF_FFFF;
   localparam int Q_MIN = 32'sh8000_0000;
   localparam int Q_ONE = 32'sh0001_0000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [LANES-1:0][31:0] first;
      logic [LANES-1:0][31:0] second;
   } obj_pair_type;

   typedef struct packed {
      logic [1:0]  order;
      logic        first_before;
      logic [34:0] diff;
   } verdict_type;

   typedef enum logic {STEP_WRITE, STEP_ITEM} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic [2:0]    index;
      logic [63:0]   data;
      obj_pair_type  pair;
      logic          typed;
      verdict_type   want;
   } plan_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mdc_req_if req_bus();
   mdc_rsp_if rsp_bus();
   mdc_csr_if csr_bus();

   multiobjective_dominance_compare #(.MAX_OBJECTIVES(LANES)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   logic [2:0]  mode_reg = mdc_pkg::MODE_FIRST;
   logic [2:0]  count_reg = mdc_pkg::COUNT_RESET;
   logic [1:0]  select_reg = '0;
   logic [63:0] weight_reg = '0;
   logic [63:0] epsilon_reg = '0;

   verdict_type   pending_verdicts[$];
   plan_step_type directed_plan[$];
   int            error_count = 0;
   int            quiet_cycles = 0;
   bit            stalls_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int order_of(input longint x, input longint y);
      return (x < y) ? -1 : ((x > y) ? 1 : 0);
   endfunction

   function automatic verdict_type compute_dominance(input obj_pair_type p);
      longint   lhs[LANES];
      longint   rhs[LANES];
      longint   a, b, w, e, wsum;
      logic [63:0] shifted;
      int       n, i, c, res;
      verdict_type v;
      wsum = 0;
      res = 0;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > LANES) n = LANES;
      for (i = 0; i < LANES; i++) begin
         a = longint'($signed(p.first[i]));
         b = longint'($signed(p.second[i]));
         w = longint'(weight_reg[16*i +: 16]);
         e = (mode_reg == mdc_pkg::MODE_EPSILON) ? longint'(epsilon_reg[16*i +: 16]) : 0;
         lhs[i] = a * (65536 + e);
         rhs[i] = b * 65536;
         if (i < n) wsum += w * (a - b);
      end
      case (mode_reg)
         mdc_pkg::MODE_FIRST: res = order_of(lhs[0], rhs[0]);
         mdc_pkg::MODE_PARETO: begin
            for (i = 0; i < n; i++) begin
               c = order_of(lhs[i], rhs[i]);
               if (c != 0) begin
                  if (res == -c) begin
                     res = 0;
                     break;
                  end
                  res = c;
               end
            end
         end
         mdc_pkg::MODE_WEAK, mdc_pkg::MODE_EPSILON: begin
            res = (lhs[0] <= rhs[0]) ? -1 : 1;
            for (i = 1; i < n; i++) begin
               if ((res == 1 && lhs[i] < rhs[i]) || (res == -1 && lhs[i] > rhs[i])) begin
                  res = 0;
                  break;
               end
            end
         end
         mdc_pkg::MODE_STRONG: begin
            res = order_of(lhs[0], rhs[0]);
            for (i = 1; i < n && res != 0; i++) begin
               if (order_of(lhs[i], rhs[i]) != res) res = 0;
            end
         end
         mdc_pkg::MODE_SCALAR: res = order_of(wsum, 0);
         mdc_pkg::MODE_SELECT: begin
            if (select_reg < n) res = order_of(lhs[select_reg], rhs[select_reg]);
         end
         default: res = 0;
      endcase
      shifted = wsum >>> 16;
      v.order = (res == -1) ? mdc_pkg::ORDER_FIRST :
                ((res == 1) ? mdc_pkg::ORDER_SECOND : mdc_pkg::ORDER_NONE);
      v.first_before = (res == -1);
      v.diff = shifted[34:0];
      return v;
   endfunction

   function automatic obj_pair_type vec(input int a0, input int a1, input int a2, input int a3,
                                        input int b0, input int b1, input int b2, input int b3);
      obj_pair_type p;
      p.first = {a3, a2, a1, a0};
      p.second = {b3, b2, b1, b0};
      return p;
   endfunction

   function automatic void add_write(input logic [2:0] idx, input logic [63:0] value);
      plan_step_type s;
      s = '0;
      s.kind = STEP_WRITE;
      s.index = idx;
      s.data = value;
      directed_plan.push_back(s);
   endfunction

   function automatic void add_item(input obj_pair_type p);
      plan_step_type s;
      s = '0;
      s.kind = STEP_ITEM;
      s.pair = p;
      directed_plan.push_back(s);
   endfunction

   function automatic void add_checked(input obj_pair_type p, input logic [1:0] order,
                                       input logic [34:0] diff);
      plan_step_type s;
      s = '0;
      s.kind = STEP_ITEM;
      s.pair = p;
      s.typed = 1'b1;
      s.want.order = order;
      s.want.first_before = (order == mdc_pkg::ORDER_FIRST);
      s.want.diff = diff;
      directed_plan.push_back(s);
   endfunction

   function automatic obj_pair_type random_pair();
      obj_pair_type p;
      int     bias, dir, pick, i;
      longint a, b, d;
      bias = $urandom_range(0, 3);
      for (i = 0; i < LANES; i++) begin
         pick = $urandom_range(0, 7);
         if (pick == 0) b = longint'(Q_MAX);
         else if (pick == 1) b = longint'(Q_MIN);
         else if (pick == 2) b = longint'($urandom_range(0, 131072)) - 65536;
         else b = longint'($signed($urandom));
         dir = (bias == 0) ? -1 : ((bias == 1) ? 1 : ($urandom_range(0, 1) ? 1 : -1));
         pick = $urandom_range(0, 9);
         d = longint'($urandom_range(1, 65536 << $urandom_range(0, 12)));
         if (bias == 3 || pick == 9) begin
            a = longint'($signed($urandom));
         end else if (pick <= 2) begin
            a = b;
         end else begin
            if (pick == 8) dir = -dir;
            a = b + dir * d;
            if (a > longint'(Q_MAX)) a = longint'(Q_MAX);
            if (a < longint'(Q_MIN)) a = longint'(Q_MIN);
         end
         p.first[i] = a[31:0];
         p.second[i] = b[31:0];
      end
      return p;
   endfunction

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         mdc_pkg::REG_MODE:     mode_reg = value[2:0];
         mdc_pkg::REG_COUNT:    count_reg = value[2:0];
         mdc_pkg::REG_SELECT:   select_reg = value[1:0];
         mdc_pkg::REG_WEIGHTS:  weight_reg = value;
         mdc_pkg::REG_EPSILONS: epsilon_reg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_word(input obj_pair_type p, input logic typed, input verdict_type want);
      req_bus.valid <= 1'b1;
      req_bus.first_obj0 <= p.first[0];
      req_bus.first_obj1 <= p.first[1];
      req_bus.first_obj2 <= p.first[2];
      req_bus.first_obj3 <= p.first[3];
      req_bus.second_obj0 <= p.second[0];
      req_bus.second_obj1 <= p.second[1];
      req_bus.second_obj2 <= p.second[2];
      req_bus.second_obj3 <= p.second[3];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_verdicts.push_back(typed ? want : compute_dominance(p));
   endtask

   task automatic sender_gap();
      if (stalls_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected word, order %b diff %0d", $time, rsp_bus.order,
                     rsp_bus.weighted_difference);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_bus.order !== want.order) begin
               $display("%0t: order expected %b actual %b", $time, want.order, rsp_bus.order);
               error_count++;
            end
            if (rsp_bus.first_before !== want.first_before) begin
               $display("%0t: first_before expected %b actual %b", $time, want.first_before,
                        rsp_bus.first_before);
               error_count++;
            end
            if (rsp_bus.weighted_difference !== want.diff) begin
               $display("%0t: weighted_difference expected %0d actual %0d", $time,
                        $signed(want.diff), rsp_bus.weighted_difference);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_multiobjective_dominance_compare: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [63:0] value;
      int          phase, k;
      req_bus.valid <= 1'b0;
      req_bus.first_obj0 <= '0;
      req_bus.first_obj1 <= '0;
      req_bus.first_obj2 <= '0;
      req_bus.first_obj3 <= '0;
      req_bus.second_obj0 <= '0;
      req_bus.second_obj1 <= '0;
      req_bus.second_obj2 <= '0;
      req_bus.second_obj3 <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;

      add_checked(vec(Q_MIN, 0, 0, 0, Q_MAX, 0, 0, 0), mdc_pkg::ORDER_FIRST, '0);
      add_checked(vec(Q_MAX, 0, 0, 0, Q_MIN, 0, 0, 0), mdc_pkg::ORDER_SECOND, '0);
      add_checked(vec(0, 0, 0, 0, 0, 0, 0, 0), mdc_pkg::ORDER_NONE, '0);
      add_write(mdc_pkg::REG_WEIGHTS, ALL_ONES);
      add_item(vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      add_item(vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      add_write(mdc_pkg::REG_MODE, mdc_pkg::MODE_PARETO);
      add_item(vec(Q_ONE, 0, -Q_ONE, 5, Q_ONE, 1, 0, 5));
      add_item(vec(0, 2, 0, 0, 1, 1, 0, 0));
      add_item(vec(3, 3, 3, 3, 3, 2, 3, 3));
      add_write(mdc_pkg::REG_MODE, mdc_pkg::MODE_WEAK);
      add_checked(vec(Q_ONE, 2, 3, 4, Q_ONE, 2, 3, 4), mdc_pkg::ORDER_FIRST, '0);
      add_item(vec(5, 0, 9, 9, 4, 1, 9, 9));
      add_write(mdc_pkg::REG_MODE, mdc_pkg::MODE_STRONG);
      add_item(vec(1, 1, 1, 1, 2, 2, 2, 2));
      add_item(vec(1, 1, 2, 1, 2, 2, 2, 2));
      add_write(mdc_pkg::REG_EPSILONS, ALL_ONES);
      add_write(mdc_pkg::REG_MODE, mdc_pkg::MODE_EPSILON);
      add_item(vec(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
      add_item(vec(-Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE));
      add_item(vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      add_write(mdc_pkg::REG_MODE, mdc_pkg::MODE_SCALAR);
      add_write(mdc_pkg::REG_WEIGHTS, 64'h0001_8000_4000_FFFF);
      add_item(vec(Q_ONE, 0, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE));
      add_item(vec(0, 0, 0, 0, 0, 0, 0, 0));
      add_write(mdc_pkg::REG_MODE, mdc_pkg::MODE_SELECT);
      add_write(mdc_pkg::REG_SELECT, 64'd3);
      add_item(vec(0, 0, 0, -5, 0, 0, 0, 5));
      add_write(mdc_pkg::REG_COUNT, 64'd2);
      add_checked(vec(0, 0, 0, -5, 0, 0, 0, 5), mdc_pkg::ORDER_NONE, '0);
      add_write(mdc_pkg::REG_COUNT, 64'd0);
      add_write(mdc_pkg::REG_SELECT, 64'd0);
      add_item(vec(-1, 7, 7, 7, 0, 0, 0, 0));
      add_write(mdc_pkg::REG_COUNT, 64'd7);
      add_write(mdc_pkg::REG_MODE, mdc_pkg::MODE_PARETO);
      add_item(vec(0, 0, 0, -1, 0, 0, 0, 0));
      add_write(mdc_pkg::REG_MODE, ALL_ONES);
      add_item(vec(Q_MIN, 3, Q_MAX, 0, Q_MAX, 4, Q_MIN, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_WRITE) begin
            drain_results();
            write_reg(directed_plan[i].index, directed_plan[i].data);
         end else begin
            sender_gap();
            send_word(directed_plan[i].pair, directed_plan[i].typed, directed_plan[i].want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         stalls_on = !(phase % 3 == 2 || phase == PHASES - 1);
         value = {$urandom, $urandom};
         value[2:0] = (phase == 8) ? 3'(mdc_pkg::MODE_EPSILON) :
                      ((phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7)));
         write_reg(mdc_pkg::REG_MODE, value);
         value = {$urandom, $urandom};
         value[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                   : 3'($urandom_range(1, 4));
         write_reg(mdc_pkg::REG_COUNT, value);
         write_reg(mdc_pkg::REG_SELECT, {$urandom, $urandom});
         if (phase == 0 || phase == 5) value = ALL_ONES;
         else if (phase == 1) value = '0;
         else value = {$urandom, $urandom};
         write_reg(mdc_pkg::REG_WEIGHTS, value);
         if (phase == 4) value = ALL_ONES;
         else if (phase == 8) value = '0;
         else value = {$urandom, $urandom};
         write_reg(mdc_pkg::REG_EPSILONS, value);
         for (k = 0; k < PHASE_WORDS; k++) begin
            sender_gap();
            send_word(random_pair(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_multiobjective_dominance_compare: done, clean");
      end else begin
         $display("tb_multiobjective_dominance_compare: done, errors");
      end
      $finish;
   end

endmodule
